@@ sv/amac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amac_pkg
// shared types and codes of the aloha ack/retransmit mac
// ----------------------------------------------------------------------------
package amac_pkg;

  localparam int SEEN_DEPTH_DEF    = 128;
  localparam int PENDING_DEPTH_DEF = 16;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RX   = 2'd1;
  localparam logic [1:0] OP_TMO  = 2'd2;

  localparam logic [2:0] ACT_DATA    = 3'd0;
  localparam logic [2:0] ACT_ACK     = 3'd1;
  localparam logic [2:0] ACT_DELIVER = 3'd2;
  localparam logic [2:0] ACT_TIMER   = 3'd3;
  localparam logic [2:0] ACT_DONE    = 3'd4;

  localparam logic [1:0] REG_SELF  = 2'd0;
  localparam logic [1:0] REG_MIN   = 2'd1;
  localparam logic [1:0] REG_RANGE = 2'd2;
  localparam logic [1:0] REG_RETRY = 2'd3;

  localparam logic [7:0]  BCAST_ADDR = 8'd255;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;

  typedef struct packed {
    logic [15:0] serial;
    logic [7:0]  dest;
    logic [7:0]  source;
    logic [3:0]  tries;
  } pend_entry_t;

  typedef struct packed {
    logic [15:0] serial;
    logic [7:0]  source;
  } seen_entry_t;

endpackage

@@ sv/amac_seen_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amac_seen_mem
// ring of recently received (serial, source) pairs, registered read
// ----------------------------------------------------------------------------
module amac_seen_mem
  import amac_pkg::*;
#(
  parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(SEEN_DEPTH)-1:0] rd_addr,
  output seen_entry_t                   rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(SEEN_DEPTH)-1:0] wr_addr,
  input  seen_entry_t                   wr_data
);

  seen_entry_t mem [SEEN_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/amac_pend_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amac_pend_mem
// pending frame table with per-entry valid flags, registered read
// ----------------------------------------------------------------------------
module amac_pend_mem
  import amac_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [$clog2(PENDING_DEPTH)-1:0] rd_addr,
  output pend_entry_t                      rd_data,
  input  logic                             wr_en,
  input  logic [$clog2(PENDING_DEPTH)-1:0] wr_addr,
  input  pend_entry_t                      wr_data,
  input  logic                             vld_we,
  input  logic [$clog2(PENDING_DEPTH)-1:0] vld_idx,
  input  logic                             vld_val,
  output logic [PENDING_DEPTH-1:0]         vld
);

  pend_entry_t mem [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] vld_r;

  assign vld = vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (vld_we) begin
      vld_r[vld_idx] <= vld_val;
    end
  end

endmodule

@@ sv/amac_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amac_mod
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module amac_mod
  import amac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [14:0] divisor,
  output logic        done,
  output logic [14:0] rem
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [15:0] dvd_r;
  logic [14:0] dvs_r;
  logic [14:0] rem_r;
  logic [15:0] trial;
  logic [15:0] diff;

  assign trial = {rem_r, dvd_r[15]};
  assign diff  = trial - {1'b0, dvs_r};
  assign done  = done_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[14:0], 1'b0};
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= diff[14:0];
        end else begin
          rem_r <= trial[14:0];
        end
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/aloha_ack_retransmit_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aloha_ack_retransmit_mac
// aloha mac with acknowledgement, duplicate filter and retransmission
// ----------------------------------------------------------------------------
// The input channel takes send requests, received frame headers and
// retransmit timeouts; the output channel gives zero to three result items
// per input item, the final one flagged by out_last. One item is worked on
// at a time: in_stall is high from acceptance until the last result has
// been loaded into the output register.
// Work per item: a send, a received ack or a timeout walks the pending
// table whether it matches or not, then runs the bit-serial remainder
// unit when a timer is set; a data frame for this node walks the seen
// ring; then one result per cycle while out_stall is low. The table
// walks go through the registered memory read ports. A broadcast send
// skips the walk; non-broadcast data frames for another node and the
// undefined operation finish at acceptance with no results.
// When the receiver stalls, the output item holds and the block waits in
// its result phase. Reset (synchronous, rst_n low) clears the pending
// valid flags, the seen ring fill count, serial and drop counters, seeds
// the backoff lfsr and restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module aloha_ack_retransmit_mac
  import amac_pkg::*;
#(
  parameter int SEEN_DEPTH    = SEEN_DEPTH_DEF,
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_dest_address,
  input  logic [7:0]  in_source_address,
  input  logic [15:0] in_frame_serial,
  input  logic        in_frame_is_ack,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [15:0] out_serial,
  output logic [7:0]  out_dest,
  output logic [7:0]  out_source,
  output logic [15:0] out_timer_delay,
  output logic [15:0] out_drop_count,
  output logic        out_last
);

  localparam int SW = $clog2(SEEN_DEPTH);
  localparam int PW = $clog2(PENDING_DEPTH);
  localparam logic [SW-1:0] S_LAST = SW'(SEEN_DEPTH - 1);
  localparam logic [PW-1:0] P_LAST = PW'(PENDING_DEPTH - 1);
  localparam logic [SW:0]   S_FULL = (SW + 1)'(SEEN_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PSCAN = 3'd1;
  localparam logic [2:0] ST_PACT  = 3'd2;
  localparam logic [2:0] ST_SSCAN = 3'd3;
  localparam logic [2:0] ST_SACT  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]  state_r;
  logic [7:0]  self_r;
  logic [14:0] min_r;
  logic [14:0] range_r;
  logic [3:0]  retry_r;

  logic [1:0]  op_r;
  logic [7:0]  dst_r;
  logic [7:0]  src_r;
  logic [15:0] cur_r;
  logic [15:0] next_serial_r;
  logic [15:0] lfsr_r;
  logic [15:0] dropped_r;
  logic [15:0] delay_r;

  logic [2:0]  res_act_r [3];
  logic [7:0]  res_dst_r [3];
  logic [7:0]  res_src_r [3];
  logic [1:0]  k_r;
  logic [1:0]  n_r;

  logic          piss_r, pchk_v_r;
  logic [PW-1:0] pcnt_r, pchk_idx_r;
  logic          found_r, free_found_r;
  logic [PW-1:0] hit_idx_r, free_idx_r;
  pend_entry_t   hit_r;

  logic          siss_r, schk_v_r;
  logic [SW-1:0] scnt_r, schk_idx_r;
  logic [SW-1:0] sptr_r;
  logic [SW:0]   sfill_r;
  logic          dup_r;

  pend_entry_t             prd;
  logic [PENDING_DEPTH-1:0] pvld;
  seen_entry_t             srd;

  logic          p_we, v_we, v_val, s_we, div_start, div_done;
  logic [PW-1:0] p_waddr, v_idx, use_idx;
  pend_entry_t   p_wdata;
  logic [14:0]   div_rem;
  logic [15:0]   lfsr_nxt;
  logic [3:0]    tries_dec;
  logic          slot_ok, pmatch, smatch, pv;
  logic [3:0]    retry_eff;
  logic [14:0]   range_eff;

  assign in_stall  = (state_r != ST_IDLE);
  assign lfsr_nxt  = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
  assign tries_dec = (hit_r.tries == 4'd0) ? 4'd0 : hit_r.tries - 4'd1;
  assign slot_ok   = found_r | free_found_r;
  assign use_idx   = found_r ? hit_idx_r : free_idx_r;
  assign retry_eff = (retry_r == 4'd0) ? 4'd1 : retry_r;
  assign range_eff = (range_r == 15'd0) ? 15'd1 : range_r;
  assign pv        = pvld[pchk_idx_r];
  assign pmatch    = pv && prd.serial == cur_r &&
                     (op_r != OP_RX || (prd.dest == src_r && prd.source == dst_r));
  assign smatch    = ({1'b0, schk_idx_r} < sfill_r) && srd.serial == cur_r &&
                     srd.source == src_r;

  always_comb begin
    p_we      = 1'b0;
    p_waddr   = use_idx;
    p_wdata   = '{serial: cur_r, dest: dst_r, source: self_r, tries: retry_eff};
    v_we      = 1'b0;
    v_idx     = use_idx;
    v_val     = 1'b1;
    div_start = 1'b0;
    if (state_r == ST_PACT) begin
      case (op_r)
        OP_SEND: begin
          p_we      = slot_ok;
          v_we      = slot_ok;
          div_start = slot_ok;
        end
        OP_RX: begin
          v_we  = found_r;
          v_idx = hit_idx_r;
          v_val = 1'b0;
        end
        OP_TMO: begin
          p_waddr = hit_idx_r;
          v_idx   = hit_idx_r;
          v_val   = 1'b0;
          p_wdata = '{serial: cur_r, dest: hit_r.dest, source: hit_r.source,
                      tries: tries_dec};
          if (found_r) begin
            if (tries_dec == 4'd0) begin
              v_we = 1'b1;
            end else begin
              p_we      = 1'b1;
              div_start = 1'b1;
            end
          end
        end
        default: begin
          p_we = 1'b0;
        end
      endcase
    end
  end

  assign s_we = (state_r == ST_SACT);

  amac_pend_mem #(.PENDING_DEPTH(PENDING_DEPTH)) u_pend (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (piss_r),
    .rd_addr (pcnt_r),
    .rd_data (prd),
    .wr_en   (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .vld_we  (v_we),
    .vld_idx (v_idx),
    .vld_val (v_val),
    .vld     (pvld)
  );

  amac_seen_mem #(.SEEN_DEPTH(SEEN_DEPTH)) u_seen (
    .clk     (clk),
    .rd_en   (siss_r),
    .rd_addr (scnt_r),
    .rd_data (srd),
    .wr_en   (s_we),
    .wr_addr (sptr_r),
    .wr_data ('{serial: cur_r, source: src_r})
  );

  amac_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lfsr_nxt),
    .divisor  (range_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      self_r        <= 8'd0;
      min_r         <= 15'd1;
      range_r       <= 15'd1;
      retry_r       <= 4'd3;
      next_serial_r <= '0;
      lfsr_r        <= LFSR_SEED;
      dropped_r     <= '0;
      out_valid     <= 1'b0;
      piss_r        <= 1'b0;
      pchk_v_r      <= 1'b0;
      siss_r        <= 1'b0;
      schk_v_r      <= 1'b0;
      sptr_r        <= '0;
      sfill_r       <= '0;
      k_r           <= '0;
      n_r           <= '0;
    end else begin
      pchk_v_r   <= piss_r;
      pchk_idx_r <= pcnt_r;
      if (piss_r) begin
        if (pcnt_r == P_LAST) begin
          piss_r <= 1'b0;
        end else begin
          pcnt_r <= pcnt_r + PW'(1);
        end
      end
      schk_v_r   <= siss_r;
      schk_idx_r <= scnt_r;
      if (siss_r) begin
        if (scnt_r == S_LAST) begin
          siss_r <= 1'b0;
        end else begin
          scnt_r <= scnt_r + SW'(1);
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_SELF:  self_r  <= cfg_wdata[7:0];
          REG_MIN:   min_r   <= cfg_wdata;
          REG_RANGE: range_r <= cfg_wdata;
          REG_RETRY: retry_r <= cfg_wdata[3:0];
          default:   self_r  <= self_r;
        endcase
      end

      if (out_valid && !out_stall && state_r != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r         <= in_operation;
            dst_r        <= in_dest_address;
            src_r        <= in_source_address;
            cur_r        <= in_frame_serial;
            k_r          <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            dup_r        <= 1'b0;
            pcnt_r       <= '0;
            scnt_r       <= '0;
            case (in_operation)
              OP_SEND: begin
                cur_r         <= next_serial_r;
                next_serial_r <= next_serial_r + 16'd1;
                res_act_r[0]  <= ACT_DATA;
                res_dst_r[0]  <= in_dest_address;
                res_src_r[0]  <= self_r;
                if (in_dest_address == BCAST_ADDR) begin
                  res_act_r[1] <= ACT_DONE;
                  res_dst_r[1] <= in_dest_address;
                  res_src_r[1] <= self_r;
                  n_r          <= 2'd2;
                  state_r      <= ST_EMIT;
                end else begin
                  piss_r  <= 1'b1;
                  state_r <= ST_PSCAN;
                end
              end
              OP_RX: begin
                if (in_frame_is_ack) begin
                  piss_r  <= 1'b1;
                  state_r <= ST_PSCAN;
                end else if (in_dest_address == self_r) begin
                  siss_r  <= 1'b1;
                  state_r <= ST_SSCAN;
                end else if (in_dest_address == BCAST_ADDR) begin
                  res_act_r[0] <= ACT_DELIVER;
                  res_dst_r[0] <= in_dest_address;
                  res_src_r[0] <= in_source_address;
                  n_r          <= 2'd1;
                  state_r      <= ST_EMIT;
                end
              end
              OP_TMO: begin
                piss_r  <= 1'b1;
                state_r <= ST_PSCAN;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end

        ST_PSCAN: begin
          if (pchk_v_r) begin
            if (!found_r && pmatch) begin
              found_r   <= 1'b1;
              hit_idx_r <= pchk_idx_r;
              hit_r     <= prd;
            end
            if (!free_found_r && !pv) begin
              free_found_r <= 1'b1;
              free_idx_r   <= pchk_idx_r;
            end
            if (pchk_idx_r == P_LAST) begin
              state_r <= ST_PACT;
            end
          end
        end

        ST_PACT: begin
          case (op_r)
            OP_SEND: begin
              if (slot_ok) begin
                lfsr_r       <= lfsr_nxt;
                res_act_r[1] <= ACT_TIMER;
                res_dst_r[1] <= dst_r;
                res_src_r[1] <= self_r;
                res_act_r[2] <= ACT_DONE;
                res_dst_r[2] <= dst_r;
                res_src_r[2] <= self_r;
                n_r          <= 2'd3;
                state_r      <= ST_DIV;
              end else begin
                res_act_r[1] <= ACT_DONE;
                res_dst_r[1] <= dst_r;
                res_src_r[1] <= self_r;
                n_r          <= 2'd2;
                state_r      <= ST_EMIT;
              end
            end
            OP_TMO: begin
              if (found_r) begin
                res_act_r[0] <= ACT_DATA;
                res_dst_r[0] <= hit_r.dest;
                res_src_r[0] <= hit_r.source;
                if (tries_dec == 4'd0) begin
                  if (dropped_r != 16'hFFFF) begin
                    dropped_r <= dropped_r + 16'd1;
                  end
                  n_r     <= 2'd1;
                  state_r <= ST_EMIT;
                end else begin
                  lfsr_r       <= lfsr_nxt;
                  res_act_r[1] <= ACT_TIMER;
                  res_dst_r[1] <= hit_r.dest;
                  res_src_r[1] <= hit_r.source;
                  n_r          <= 2'd2;
                  state_r      <= ST_DIV;
                end
              end else begin
                state_r <= ST_IDLE;
              end
            end
            default: begin
              state_r <= ST_IDLE;
            end
          endcase
        end

        ST_SSCAN: begin
          if (schk_v_r) begin
            if (smatch) begin
              dup_r <= 1'b1;
            end
            if (schk_idx_r == S_LAST) begin
              state_r <= ST_SACT;
            end
          end
        end

        ST_SACT: begin
          sptr_r <= (sptr_r == S_LAST) ? '0 : sptr_r + SW'(1);
          if (sfill_r != S_FULL) begin
            sfill_r <= sfill_r + (SW + 1)'(1);
          end
          if (dup_r) begin
            res_act_r[0] <= ACT_ACK;
            res_dst_r[0] <= src_r;
            res_src_r[0] <= self_r;
            n_r          <= 2'd1;
          end else begin
            res_act_r[0] <= ACT_DELIVER;
            res_dst_r[0] <= dst_r;
            res_src_r[0] <= src_r;
            res_act_r[1] <= ACT_ACK;
            res_dst_r[1] <= src_r;
            res_src_r[1] <= self_r;
            n_r          <= 2'd2;
          end
          state_r <= ST_EMIT;
        end

        ST_DIV: begin
          if (div_done) begin
            delay_r <= {1'b0, min_r} + {1'b0, div_rem};
            state_r <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            out_action      <= res_act_r[k_r];
            out_serial      <= cur_r;
            out_dest        <= res_dst_r[k_r];
            out_source      <= res_src_r[k_r];
            out_timer_delay <= (res_act_r[k_r] == ACT_TIMER) ? delay_r : 16'd0;
            out_drop_count  <= dropped_r;
            out_last        <= (k_r == n_r - 2'd1);
            if (k_r == n_r - 2'd1) begin
              state_r <= ST_IDLE;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (k_r < n_r))
    else $error("result index beyond result count");

  a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (dropped_r >= $past(dropped_r)))
    else $error("drop counter decreased");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sfill_r <= S_FULL)
    else $error("seen ring fill count overflow");

endmodule
